FILE: hdl/ttb_pkg.sv
`timescale 1ns / 1ps
package ttb_pkg;

	localparam int PosW  = 33;
	localparam int TexW  = 17;
	localparam int DetW  = 35;
	localparam int RawW  = 51;
	localparam int MagW  = 50;
	localparam int MulW  = 34;
	localparam int ProdW = 68;
	localparam int QW    = 15;
	localparam int SumW  = 32;
	localparam int SqW   = 30;
	localparam int OutW  = 16;
	localparam int BitW  = 4;

	localparam logic [QW-1:0] UNIT_Q14 = 15'd16384;
	localparam logic [BitW-1:0] TOP_BIT = 4'd14;

	localparam logic [1:0] CORNER_0 = 2'd0;
	localparam logic [1:0] CORNER_1 = 2'd1;
	localparam logic [1:0] CORNER_2 = 2'd2;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic signed [15:0] tan_x;
		logic signed [15:0] tan_y;
		logic signed [15:0] tan_z;
		logic signed [15:0] bin_x;
		logic signed [15:0] bin_y;
		logic signed [15:0] bin_z;
		logic               degenerate;
	} basis_t;

	typedef struct packed {
		logic [2:0][PosW-1:0] d1;
		logic [2:0][PosW-1:0] d2;
		logic [TexW-1:0]      du1;
		logic [TexW-1:0]      dv1;
		logic [TexW-1:0]      du2;
		logic [TexW-1:0]      dv2;
	} delta_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DET, S_VEC, S_MAG, S_SHIFT, S_SQ, S_BIT, S_DONE
	} state_t;

endpackage

FILE: hdl/ttb_mul.sv
`timescale 1ns / 1ps
module ttb_mul import ttb_pkg::*; (
	input  logic                    clk,
	input  logic signed [MulW-1:0]  a,
	input  logic signed [MulW-1:0]  b,
	output logic signed [ProdW-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

FILE: hdl/ttb_hold.sv
`timescale 1ns / 1ps
module ttb_hold import ttb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  vtx_t   vtx,
	output delta_t delta
);

	logic [2:0][31:0] p0_q, p1_q;
	logic [15:0]      u0_q, v0_q, u1_q, v1_q;
	logic [2:0][31:0] p2;
	delta_t           delta_q;

	assign p2 = {vtx.pos_z, vtx.pos_y, vtx.pos_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q <= '0;
			p1_q <= '0;
			u0_q <= '0;
			v0_q <= '0;
			u1_q <= '0;
			v1_q <= '0;
		end else if (load) begin
			if (vtx.corner == CORNER_0) begin
				p0_q <= p2;
				u0_q <= vtx.tex_u;
				v0_q <= vtx.tex_v;
			end else if (vtx.corner == CORNER_1) begin
				p1_q <= p2;
				u1_q <= vtx.tex_u;
				v1_q <= vtx.tex_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && vtx.corner == CORNER_2) begin
			for (int i = 0; i < 3; i++) begin
				delta_q.d1[i] <= {p1_q[i][31], p1_q[i]} - {p0_q[i][31], p0_q[i]};
				delta_q.d2[i] <= {p2[i][31], p2[i]} - {p0_q[i][31], p0_q[i]};
			end
			delta_q.du1 <= {u1_q[15], u1_q} - {u0_q[15], u0_q};
			delta_q.dv1 <= {v1_q[15], v1_q} - {v0_q[15], v0_q};
			delta_q.du2 <= {vtx.tex_u[15], vtx.tex_u} - {u0_q[15], u0_q};
			delta_q.dv2 <= {vtx.tex_v[15], vtx.tex_v} - {v0_q[15], v0_q};
		end
	end

	assign delta = delta_q;

endmodule

FILE: hdl/triangle_tangent_binormal_top.sv
`timescale 1ns / 1ps
// Vertices of a triangle are transferred one at a time; corners 0 and 1 are held and corner 2
// starts the computation of the unit tangent and binormal in Q1.14. Corners 0, 1 and 3 are
// accepted without leaving the idle state. A corner 2 item keeps the input not ready until its
// result is moved into the output register, so also while the previous result still waits;
// the range reduction shifts the largest tangent and binormal magnitudes below 2^15, by 0 to 34
// bits each. A triangle with a zero determinant or a zero tangent goes to done straight after
// its first magnitude step, and one with only a zero binormal once its tangent is found. Every
// product goes through one shared registered 34 by 34 bit multiplier under a sequencer, the
// range reduction shifts one bit a cycle, and each Q1.14 output is found one bit at a time. A
// finished result waits in the output register, and vertices are still accepted while it waits.
module triangle_tangent_binormal_top import ttb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  vtx_t   in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output basis_t out_data
);

	state_t state_q, state_d;
	logic [1:0]             ph_q;
	logic [3:0]             cnt_q;
	logic                   vsel_q;
	logic [1:0]             ci_q;
	logic [BitW-1:0]        bit_q;
	logic [QW-1:0]          q_q;
	logic                   deg_q;
	logic                   out_valid_q;
	basis_t                 out_q;

	logic signed [DetW-1:0] det_q;
	logic signed [RawW-1:0] tv_q [3];
	logic signed [RawW-1:0] bv_q [3];
	logic [MagW-1:0]        a_q [3];
	logic [MagW-1:0]        m_q;
	logic [2:0]             sgn_q;
	logic [SumW-1:0]        s_q;
	logic [SqW-1:0]         sq_q [3];
	logic [OutW-1:0]        tres_q [3];
	logic [OutW-1:0]        bres_q [3];

	logic                   in_acc;
	delta_t                 delta;
	logic signed [MulW-1:0] mul_a, mul_b;
	logic signed [ProdW-1:0] prod;

	logic [1:0]             vi;
	logic [MagW-1:0]        mag [3];
	logic [2:0]             neg;
	logic [MagW-1:0]        mmax;
	logic                   is_deg;
	logic [QW-1:0]          cand, qn;
	logic [OutW-1:0]        dodd, qs;
	logic                   cmp_ok;
	logic                   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	ttb_hold u_hold (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_acc),
		.vtx    (in_data),
		.delta  (delta)
	);

	ttb_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign vi = cnt_q[3:2];

	always_comb begin
		mmax = '0;
		for (int i = 0; i < 3; i++) begin
			logic signed [RawW-1:0] c;
			c = vsel_q ? bv_q[i] : tv_q[i];
			neg[i] = c[RawW-1] ^ det_q[DetW-1];
			mag[i] = c[RawW-1] ? MagW'(-c) : MagW'(c);
			if (mag[i] > mmax) mmax = mag[i];
		end
		is_deg = (det_q == '0) || (mmax == '0);
	end

	assign cand   = q_q | (QW'(1) << bit_q);
	assign dodd   = {cand, 1'b0} - OutW'(1);
	assign cmp_ok = (prod[61:0] <= {2'b00, sq_q[ci_q], 30'b0}) && (cand <= UNIT_Q14);
	assign qn     = cmp_ok ? cand : q_q;
	assign qs     = sgn_q[ci_q] ? -{1'b0, qn} : {1'b0, qn};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DET: begin
				if (!cnt_q[0]) begin
					mul_a = MulW'($signed(delta.du1));
					mul_b = MulW'($signed(delta.dv2));
				end else begin
					mul_a = MulW'($signed(delta.dv1));
					mul_b = MulW'($signed(delta.du2));
				end
			end
			S_VEC: begin
				unique case (cnt_q[1:0])
					2'd0: begin
						mul_a = MulW'($signed(delta.d1[vi]));
						mul_b = MulW'($signed(delta.dv2));
					end
					2'd1: begin
						mul_a = MulW'($signed(delta.d2[vi]));
						mul_b = MulW'($signed(delta.dv1));
					end
					2'd2: begin
						mul_a = MulW'($signed(delta.d2[vi]));
						mul_b = MulW'($signed(delta.du1));
					end
					default: begin
						mul_a = MulW'($signed(delta.d1[vi]));
						mul_b = MulW'($signed(delta.du2));
					end
				endcase
			end
			S_SQ: begin
				mul_a = MulW'({1'b0, a_q[cnt_q[1:0]][QW-1:0]});
				mul_b = MulW'({1'b0, a_q[cnt_q[1:0]][QW-1:0]});
			end
			S_BIT: begin
				if (ph_q == 2'd0) begin
					mul_a = MulW'({1'b0, dodd});
					mul_b = MulW'({1'b0, dodd});
				end else begin
					mul_a = MulW'({1'b0, prod[SqW-1:0]});
					mul_b = MulW'({1'b0, s_q});
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_acc && in_data.corner == CORNER_2) state_d = S_DET;
			S_DET:   if (ph_q[0] && cnt_q == 4'd1) state_d = S_VEC;
			S_VEC:   if (ph_q[0] && cnt_q == 4'd11) state_d = S_MAG;
			S_MAG:   state_d = is_deg ? S_DONE : S_SHIFT;
			S_SHIFT: if (m_q[MagW-1:QW] == '0) state_d = S_SQ;
			S_SQ:    if (ph_q[0] && cnt_q == 4'd2) state_d = S_BIT;
			S_BIT: begin
				if (ph_q == 2'd2 && bit_q == '0 && ci_q == 2'd2)
					state_d = vsel_q ? S_DONE : S_MAG;
			end
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= '0;
			cnt_q       <= '0;
			vsel_q      <= 1'b0;
			ci_q        <= '0;
			bit_q       <= '0;
			deg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ph_q   <= '0;
					cnt_q  <= '0;
					vsel_q <= 1'b0;
					deg_q  <= 1'b0;
				end
				S_DET, S_VEC, S_SQ: begin
					ph_q <= {1'b0, !ph_q[0]};
					if (ph_q[0]) cnt_q <= (state_d == state_q) ? cnt_q + 4'd1 : '0;
				end
				S_MAG: begin
					deg_q <= is_deg;
					ph_q  <= '0;
					cnt_q <= '0;
				end
				S_SHIFT: begin
					ci_q  <= '0;
					bit_q <= TOP_BIT;
				end
				S_BIT: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (bit_q == '0) begin
							bit_q <= TOP_BIT;
							if (ci_q == 2'd2) begin
								ci_q   <= '0;
								vsel_q <= 1'b1;
							end else begin
								ci_q <= ci_q + 2'd1;
							end
						end else begin
							bit_q <= bit_q - BitW'(1);
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				default: ph_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DET: begin
				if (ph_q[0]) begin
					if (!cnt_q[0]) det_q <= DetW'(prod);
					else det_q <= det_q - DetW'(prod);
				end
			end
			S_VEC: begin
				if (ph_q[0]) begin
					unique case (cnt_q[1:0])
						2'd0:    tv_q[vi] <= RawW'(prod);
						2'd1:    tv_q[vi] <= tv_q[vi] - RawW'(prod);
						2'd2:    bv_q[vi] <= RawW'(prod);
						default: bv_q[vi] <= bv_q[vi] - RawW'(prod);
					endcase
				end
			end
			S_MAG: begin
				for (int i = 0; i < 3; i++) a_q[i] <= mag[i];
				m_q   <= mmax;
				sgn_q <= neg;
				s_q   <= '0;
			end
			S_SHIFT: begin
				q_q <= '0;
				if (m_q[MagW-1:QW] != '0) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
					m_q <= m_q >> 1;
				end
			end
			S_SQ: begin
				if (ph_q[0]) begin
					sq_q[cnt_q[1:0]] <= prod[SqW-1:0];
					s_q <= s_q + SumW'(prod[SqW-1:0]);
				end
			end
			S_BIT: begin
				if (ph_q == 2'd2) begin
					if (bit_q == '0) begin
						q_q <= '0;
						if (vsel_q) bres_q[ci_q] <= qs;
						else tres_q[ci_q] <= qs;
					end else begin
						q_q <= qn;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q.degenerate <= deg_q;
					out_q.tan_x <= deg_q ? '0 : tres_q[0];
					out_q.tan_y <= deg_q ? '0 : tres_q[1];
					out_q.tan_z <= deg_q ? '0 : tres_q[2];
					out_q.bin_x <= deg_q ? '0 : bres_q[0];
					out_q.bin_y <= deg_q ? '0 : bres_q[1];
					out_q.bin_z <= deg_q ? '0 : bres_q[2];
				end
			end
			default: begin
			end
		endcase
	end

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.tan_x == '0 && out_data.tan_y == '0 &&
		out_data.tan_z == '0 && out_data.bin_x == '0 && out_data.bin_y == '0 &&
		out_data.bin_z == '0)
		else $error("degenerate result carries non-zero vectors");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.tan_x <= 16'sd16384 && out_data.tan_x >= -16'sd16384 &&
		out_data.bin_x <= 16'sd16384 && out_data.bin_x >= -16'sd16384)
		else $error("unit component out of Q1.14 range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.corner == CORNER_2 |=> !in_ready)
		else $error("input ready while a triangle is being worked on");

endmodule
